// ===== hw/rtl/slps_pkg.sv =====
// Types and constants shared by the status LED pattern sequencer.
`default_nettype none

package slps_pkg;

    typedef enum logic [2:0] {
        DISP_BOOT      = 3'd0,
        DISP_AP        = 3'd1,
        DISP_IDLE      = 3'd2,
        DISP_SCANNING  = 3'd3,
        DISP_CONNECTED = 3'd4,
        DISP_RECORDING = 3'd5,
        DISP_ERROR     = 3'd6
    } t_disp;

    localparam logic [2:0] SEL_MAX = 3'd6;

    localparam logic [31:0] BOOT_PERIOD = 32'd30;
    localparam logic [6:0]  BOOT_STEP   = 7'd5;
    localparam logic [6:0]  BOOT_PEAK   = 7'd60;
    localparam logic [6:0]  BOOT_FLOOR  = 7'd0;

    localparam logic [31:0] AP_PERIOD = 32'd30;
    localparam logic [6:0]  AP_STEP   = 7'd3;
    localparam logic [6:0]  AP_PEAK   = 7'd50;
    localparam logic [6:0]  AP_FLOOR  = 7'd0;

    localparam logic [31:0] REC_PERIOD = 32'd25;
    localparam logic [6:0]  REC_STEP   = 7'd2;
    localparam logic [6:0]  REC_PEAK   = 7'd50;
    localparam logic [6:0]  REC_FLOOR  = 7'd4;

    localparam logic [31:0] SCAN_PERIOD = 32'd250;
    localparam logic [31:0] ERR_PERIOD  = 32'd100;

    localparam logic [7:0] IDLE_BLUE      = 8'd8;
    localparam logic [7:0] SCAN_BLUE      = 8'd40;
    localparam logic [7:0] CONNECTED_GRN  = 8'd30;
    localparam logic [7:0] ERR_RED        = 8'd50;

    typedef struct packed {
        t_disp       disp;
        logic [31:0] last_ms;
        logic [6:0]  level;
        logic        falling;
        logic        blink_lit;
    } t_anim;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

endpackage

`default_nettype wire

// ===== hw/rtl/status_led_pattern_sequencer_top.sv =====
// Status LED pattern sequencer top level: input register, step logic, result register.
// A tick passes from the input register through the step logic into the result register, which presents its colour.
// Throughput: one item per cycle while the master side takes each colour, set by the combinational step logic.
// Stalls: hold the input while a colour waits on the master side and the receiver holds off.
// Ticks that produce no colour and state selects leave the output untouched.
// Reset (synchronous, active low) empties both registers and returns to boot with level zero.
`default_nettype none

module status_led_pattern_sequencer_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [39:0] i_s_axis_tdata,  // now_ms [31:0], new_state [34:32], zero pad
    input  wire         i_s_axis_tuser,  // mode
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // red [7:0], green [15:8], blue [23:16]
);

    logic               r_in_valid;
    logic               r_in_mode;
    logic [31:0]        r_in_now;
    logic [2:0]         r_in_sel;
    logic               r_out_valid;
    slps_pkg::t_rgb     r_out_rgb;
    slps_pkg::t_anim    r_state;
    slps_pkg::t_anim    n_state;
    slps_pkg::t_rgb     n_rgb;
    logic               n_emit;
    logic               advance;

    slps_step u_step (
        .i_state     (r_state),
        .i_mode      (r_in_mode),
        .i_now_ms    (r_in_now),
        .i_new_state (r_in_sel),
        .o_state     (n_state),
        .o_emit      (n_emit),
        .o_rgb       (n_rgb)
    );

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_mode <= i_s_axis_tuser;
            r_in_now  <= i_s_axis_tdata[31:0];
            r_in_sel  <= i_s_axis_tdata[34:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance && n_emit) begin
            r_out_rgb <= n_rgb;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/slps_step.sv =====
// Per-item next animation state and colour for the status LED sequencer.
`default_nettype none

module slps_step (
    input  wire slps_pkg::t_anim i_state,
    input  wire                  i_mode,
    input  wire [31:0]           i_now_ms,
    input  wire [2:0]            i_new_state,
    output slps_pkg::t_anim      o_state,
    output logic                 o_emit,
    output slps_pkg::t_rgb       o_rgb
);

    logic [31:0] elapsed;
    logic [31:0] period;
    logic [6:0]  step;
    logic [6:0]  peak;
    logic [6:0]  floor_v;
    logic        passed;
    logic [7:0]  up_sum;
    logic [6:0]  moved;
    logic [6:0]  br_level;
    logic        br_falling;

    assign elapsed = i_now_ms - i_state.last_ms;
    assign passed  = (elapsed > period);

    always_comb begin
        period  = slps_pkg::BOOT_PERIOD;
        step    = slps_pkg::BOOT_STEP;
        peak    = slps_pkg::BOOT_PEAK;
        floor_v = slps_pkg::BOOT_FLOOR;
        case (i_state.disp)
            slps_pkg::DISP_AP: begin
                period  = slps_pkg::AP_PERIOD;
                step    = slps_pkg::AP_STEP;
                peak    = slps_pkg::AP_PEAK;
                floor_v = slps_pkg::AP_FLOOR;
            end
            slps_pkg::DISP_RECORDING: begin
                period  = slps_pkg::REC_PERIOD;
                step    = slps_pkg::REC_STEP;
                peak    = slps_pkg::REC_PEAK;
                floor_v = slps_pkg::REC_FLOOR;
            end
            slps_pkg::DISP_SCANNING: period = slps_pkg::SCAN_PERIOD;
            slps_pkg::DISP_ERROR:    period = slps_pkg::ERR_PERIOD;
            default: ;
        endcase
    end

    // Breathing: move one step, turn at the peak, clamp at the floor
    always_comb begin
        up_sum = {1'b0, i_state.level} + {1'b0, step};
        if (i_state.falling) begin
            moved = (i_state.level >= step) ? (i_state.level - step) : 7'd0;
        end else begin
            moved = up_sum[6:0];
        end
        br_falling = i_state.falling;
        br_level   = moved;
        if (i_state.falling ? (moved >= peak) : (up_sum >= {1'b0, peak})) begin
            br_falling = 1'b1;
        end
        if (i_state.falling ? (moved <= floor_v) : (up_sum <= {1'b0, floor_v})) begin
            br_falling = 1'b0;
            br_level   = floor_v;
        end
    end

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        o_rgb   = '0;
        if (i_mode) begin
            if (i_new_state <= slps_pkg::SEL_MAX) begin
                o_state.disp    = slps_pkg::t_disp'(i_new_state);
                o_state.last_ms = '0;
                o_state.level   = '0;
                o_state.falling = 1'b0;
            end
        end else begin
            case (i_state.disp)
                slps_pkg::DISP_BOOT, slps_pkg::DISP_AP, slps_pkg::DISP_RECORDING: begin
                    if (passed) begin
                        o_state.last_ms = i_now_ms;
                        o_state.level   = br_level;
                        o_state.falling = br_falling;
                        o_emit          = 1'b1;
                        o_rgb.red       = {1'b0, br_level};
                        if (i_state.disp == slps_pkg::DISP_BOOT) begin
                            o_rgb.green = {1'b0, br_level};
                            o_rgb.blue  = {1'b0, br_level};
                        end else if (i_state.disp == slps_pkg::DISP_AP) begin
                            o_rgb.green = {2'b00, br_level[6:1]};
                        end
                    end
                end
                slps_pkg::DISP_SCANNING, slps_pkg::DISP_ERROR: begin
                    if (passed) begin
                        o_state.last_ms   = i_now_ms;
                        o_state.blink_lit = !i_state.blink_lit;
                        o_emit            = 1'b1;
                        if (!i_state.blink_lit) begin
                            if (i_state.disp == slps_pkg::DISP_SCANNING) begin
                                o_rgb.blue = slps_pkg::SCAN_BLUE;
                            end else begin
                                o_rgb.red = slps_pkg::ERR_RED;
                            end
                        end
                    end
                end
                slps_pkg::DISP_IDLE: begin
                    o_emit     = 1'b1;
                    o_rgb.blue = slps_pkg::IDLE_BLUE;
                end
                slps_pkg::DISP_CONNECTED: begin
                    o_emit      = 1'b1;
                    o_rgb.green = slps_pkg::CONNECTED_GRN;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the status LED pattern sequencer: colour scoreboard and stream drivers.
`timescale 1ns / 100ps

class led_colour_scoreboard;
    slps_pkg::t_disp disp;
    logic [31:0]     last_ms;
    logic [6:0]      level;
    logic            falling;
    logic            blink_lit;
    slps_pkg::t_rgb  colours_due[$];
    int              errors;

    function new();
        disp      = slps_pkg::DISP_BOOT;
        last_ms   = '0;
        level     = '0;
        falling   = 1'b0;
        blink_lit = 1'b0;
        errors    = 0;
    endfunction

    function int pending();
        return colours_due.size();
    endfunction

    function bit period_over(logic [31:0] now, logic [31:0] period);
        logic [31:0] elapsed;
        elapsed = now - last_ms;
        if (elapsed > period) begin
            last_ms = now;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void breathe(logic [6:0] step, logic [6:0] peak, logic [6:0] flr);
        int lvl;
        lvl = int'(level);
        if (falling) begin
            lvl = (lvl >= int'(step)) ? lvl - int'(step) : 0;
        end else begin
            lvl = lvl + int'(step);
        end
        if (lvl >= int'(peak)) begin
            falling = 1'b1;
        end
        if (lvl <= int'(flr)) begin
            falling = 1'b0;
            lvl     = int'(flr);
        end
        level = lvl[6:0];
    endfunction

    function void note_item(bit mode, logic [31:0] now, logic [2:0] sel);
        slps_pkg::t_rgb c;
        bit             lit;
        c   = '0;
        lit = 1'b0;
        if (mode) begin
            if (sel <= slps_pkg::SEL_MAX) begin
                disp    = slps_pkg::t_disp'(sel);
                last_ms = '0;
                level   = '0;
                falling = 1'b0;
            end
            return;
        end
        case (disp)
            slps_pkg::DISP_BOOT: if (period_over(now, slps_pkg::BOOT_PERIOD)) begin
                breathe(slps_pkg::BOOT_STEP, slps_pkg::BOOT_PEAK, slps_pkg::BOOT_FLOOR);
                c.red   = {1'b0, level};
                c.green = {1'b0, level};
                c.blue  = {1'b0, level};
                lit     = 1'b1;
            end
            slps_pkg::DISP_AP: if (period_over(now, slps_pkg::AP_PERIOD)) begin
                breathe(slps_pkg::AP_STEP, slps_pkg::AP_PEAK, slps_pkg::AP_FLOOR);
                c.red   = {1'b0, level};
                c.green = {2'b00, level[6:1]};
                lit     = 1'b1;
            end
            slps_pkg::DISP_IDLE: begin
                c.blue = slps_pkg::IDLE_BLUE;
                lit    = 1'b1;
            end
            slps_pkg::DISP_SCANNING: if (period_over(now, slps_pkg::SCAN_PERIOD)) begin
                blink_lit = ~blink_lit;
                if (blink_lit) begin
                    c.blue = slps_pkg::SCAN_BLUE;
                end
                lit = 1'b1;
            end
            slps_pkg::DISP_CONNECTED: begin
                c.green = slps_pkg::CONNECTED_GRN;
                lit     = 1'b1;
            end
            slps_pkg::DISP_RECORDING: if (period_over(now, slps_pkg::REC_PERIOD)) begin
                breathe(slps_pkg::REC_STEP, slps_pkg::REC_PEAK, slps_pkg::REC_FLOOR);
                c.red = {1'b0, level};
                lit   = 1'b1;
            end
            slps_pkg::DISP_ERROR: if (period_over(now, slps_pkg::ERR_PERIOD)) begin
                blink_lit = ~blink_lit;
                if (blink_lit) begin
                    c.red = slps_pkg::ERR_RED;
                end
                lit = 1'b1;
            end
            default: ;
        endcase
        if (lit) begin
            colours_due.push_back(c);
        end
    endfunction

    function void check_colour(slps_pkg::t_rgb got);
        slps_pkg::t_rgb want;
        if (colours_due.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("colour r=%0d g=%0d b=%0d with none expected",
                         got.red, got.green, got.blue);
            end
            return;
        end
        want = colours_due.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            errors++;
            if (errors <= 10) begin
                $display("colour mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                         want.red, want.green, want.blue, got.red, got.green, got.blue);
            end
        end
    endfunction
endclass

module tb;
    localparam int RANDOM_ITEMS   = 700;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [39:0] s_data  = '0;
    logic        s_user  = 1'b0;
    logic        m_ready = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [23:0] m_data;

    led_colour_scoreboard sb = new();

    bit calm        = 1'b0;
    bit rx_hold_req = 1'b0;
    int items_sent  = 0;
    int idle_run    = 0;

    status_led_pattern_sequencer_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic int period_of(slps_pkg::t_disp d);
        case (d)
            slps_pkg::DISP_BOOT:      return int'(slps_pkg::BOOT_PERIOD);
            slps_pkg::DISP_AP:        return int'(slps_pkg::AP_PERIOD);
            slps_pkg::DISP_SCANNING:  return int'(slps_pkg::SCAN_PERIOD);
            slps_pkg::DISP_RECORDING: return int'(slps_pkg::REC_PERIOD);
            slps_pkg::DISP_ERROR:     return int'(slps_pkg::ERR_PERIOD);
            default:                  return 20;
        endcase
    endfunction

    task automatic send_item(bit mode, logic [31:0] now, logic [2:0] sel);
        int gap;
        gap = (!calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {5'b00000, sel, now};
        s_user  <= mode;
        do @(negedge i_clk); while (!s_ready);
        sb.note_item(mode, now, sel);
        items_sent++;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_sequence();
        logic [2:0]  st;
        logic [31:0] t;
        int          n;
        int          r;
        int          period;
        calm = ($urandom_range(0, 4) == 0);
        st   = ($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
        send_item(1'b1, $urandom(), st);
        period = period_of(sb.disp);
        r = $urandom_range(0, 5);
        if (r == 0) begin
            t = $urandom();
        end else if (r == 1) begin
            t = 32'hFFFF_FF00;
        end else begin
            t = 32'($urandom_range(0, 10));
        end
        n = (period < 100) ? $urandom_range(10, 80) : $urandom_range(5, 30);
        repeat (n) begin
            r = $urandom_range(0, 29);
            if (r < 21) begin
                t = t + period + $urandom_range(0, 2);
            end else if (r < 24) begin
                t = t + $urandom_range(0, period);
            end else if (r < 27) begin
                t = t + $urandom_range(0, 3 * period);
            end else if (r < 29) begin
                t = $urandom();
            end else begin
                send_item(1'b1, $urandom(), 3'($urandom_range(0, 7)));
                period = period_of(sb.disp);
            end
            send_item(1'b0, t, 3'($urandom_range(0, 7)));
        end
        if ($urandom_range(0, 9) == 0) begin
            drain();
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            sb.check_colour(slps_pkg::t_rgb'(m_data));
        end
    end

    initial begin
        int rx_stall;
        bit nxt;
        rx_stall = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_stall    = RX_HOLD_CYCLES;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                nxt = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                rx_stall = pick_gap() - 1;
                nxt      = 1'b0;
            end else begin
                nxt = 1'b1;
            end
            @(posedge i_clk);
            m_ready <= nxt;
        end
    end

    initial begin
        while (idle_run < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_run = 0;
            end else begin
                idle_run++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int base;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // boot breathing, period boundary, time wrap and an out-of-range select, then AP, idle and scanning
        send_item(1'b0, 32'd0, 3'd0);
        send_item(1'b0, 32'd30, 3'd7);
        send_item(1'b0, 32'd31, 3'd0);
        send_item(1'b0, 32'hFFFF_FFFF, 3'd0);
        send_item(1'b0, 32'd0, 3'd0);
        send_item(1'b1, 32'd0, 3'd7);
        send_item(1'b0, 32'd40, 3'd0);
        send_item(1'b1, 32'hFFFF_FFFF, slps_pkg::DISP_AP);
        send_item(1'b0, 32'd31, 3'd0);
        send_item(1'b1, 32'd0, slps_pkg::DISP_IDLE);
        send_item(1'b0, 32'd0, 3'd0);
        send_item(1'b0, 32'hFFFF_FFFF, 3'd7);
        send_item(1'b1, 32'd0, slps_pkg::DISP_SCANNING);
        send_item(1'b0, 32'd251, 3'd0);
        // blink flag carries over into the error state
        send_item(1'b1, 32'd0, slps_pkg::DISP_ERROR);
        send_item(1'b0, 32'd101, 3'd0);
        send_item(1'b1, 32'd0, slps_pkg::DISP_CONNECTED);
        send_item(1'b0, 32'd5, 3'd0);
        send_item(1'b1, 32'd0, slps_pkg::DISP_RECORDING);
        send_item(1'b0, 32'd26, 3'd0);
        send_item(1'b0, 32'd52, 3'd0);
        drain();

        // hold the receiver off while idle ticks back up into the block
        calm = 1'b1;
        send_item(1'b1, 32'd0, slps_pkg::DISP_IDLE);
        rx_hold_req = 1'b1;
        repeat (24) send_item(1'b0, $urandom(), 3'd0);
        drain();
        calm = 1'b0;

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) run_sequence();

        s_valid <= 1'b0;
        calm = 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
